@@ rtl/esf_pkg.sv @@
// Encoder speed filter: shared types, field widths, register indexes and limits.
// No dependencies; imported by every module of the block.
package esf_pkg;

	localparam int unsigned AVG_DEPTH_DEF = 16;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned PULSE_W   = 17;
	localparam int unsigned WSUM_W    = 21;
	localparam int unsigned SPEED_W   = 33;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_OFFSET = 2'd0,
		REG_SPIKE_LIMIT = 2'd1,
		REG_SPEED_SCALE = 2'd2
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] ZERO_OFFSET_RST = 16'd20000;
	localparam logic [CFG_W-1:0] SPIKE_LIMIT_RST = 16'd50;
	localparam logic [CFG_W-1:0] SPEED_SCALE_RST = 16'd4096;

	localparam longint SUM_LIMIT   = 64'sd1048560;
	localparam longint SPEED_LIMIT = 64'sd4294836225;

	typedef logic signed [PULSE_W-1:0] pulse_t;

endpackage

@@ rtl/esf_ring.sv @@
// Encoder speed filter: ring of accepted pulse counts with exact running sum.
// Depends on esf_pkg. Ring held in a memory with one registered read port.
module esf_ring import esf_pkg::*; #(
	parameter int unsigned AVG_DEPTH = AVG_DEPTH_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       en,
	input  pulse_t                                     pulse,
	output logic signed [PULSE_W+$clog2(AVG_DEPTH)-1:0] sum_next
);

	localparam int unsigned IDX_W = $clog2(AVG_DEPTH);
	localparam int unsigned SUM_W = PULSE_W + IDX_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(AVG_DEPTH - 1);

	pulse_t                   mem [AVG_DEPTH];
	logic [AVG_DEPTH-1:0]     vld_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         wr_idx;
	logic [IDX_W-1:0]         rd_idx;
	pulse_t                   rd_data_q;
	logic                     rd_vld_q;
	pulse_t                   old_val;
	logic signed [SUM_W-1:0]  sum_q;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_LAST) ? '0 : i + 1'b1;
	endfunction

	// next slot to write, and the slot after it (prefetched for the next item)
	assign wr_idx   = wrap_inc(idx_q);
	assign rd_idx   = wrap_inc(wr_idx);
	assign old_val  = rd_vld_q ? rd_data_q : '0;
	assign sum_next = sum_q - SUM_W'(old_val) + SUM_W'(pulse);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			sum_q    <= '0;
		end else if (en) begin
			idx_q         <= wr_idx;
			vld_q[wr_idx] <= 1'b1;
			rd_vld_q      <= vld_q[rd_idx];
			sum_q         <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mem[wr_idx] <= pulse;
			rd_data_q   <= mem[rd_idx];
		end
	end

endmodule

@@ rtl/encoder_speed_filter_core.sv @@
// Encoder speed filter top level: spike rejection, moving average and speed scaling.
// Depends on esf_pkg and esf_ring. Checker attached from esf_checker.sv.
//
// One wheel encoder per instance. Each item is a raw counter value; the pulse count is
// zero_offset minus that value, replaced by the last accepted count when it moves by more
// than spike_limit. Accepted counts enter a ring of AVG_DEPTH entries (a power of two,
// 2 to 256) and the speed is floor(sum * speed_scale / AVG_DEPTH) in Q.12 units, saturated.
// One item is taken every cycle while tick_stall is low; an accepted item passes through the
// input, window sum, scaled sum and result registers. The ring sits in a memory whose single
// read port prefetches the entry leaving the sum next; per-entry valid bits make it read as
// zero after reset, so no clearing pass is needed. tick_stall comes from a one-item skid
// register and rises only while the result side is stalled.
module encoder_speed_filter_core import esf_pkg::*; #(
	parameter int unsigned AVG_DEPTH = AVG_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       tick_valid,
	output logic                       tick_stall,
	input  logic [CNT_W-1:0]           counter_value,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [PULSE_W-1:0]  accepted_pulse,
	output logic                       spike_rejected,
	output logic signed [WSUM_W-1:0]   window_sum,
	output logic signed [SPEED_W-1:0]  avg_speed,
	output logic signed [SPEED_W-1:0]  previous_speed
);

	localparam int unsigned SHIFT  = $clog2(AVG_DEPTH);
	localparam int unsigned SUM_W  = PULSE_W + SHIFT;
	localparam int unsigned PROD_W = SUM_W + CFG_W + 1;
	localparam int unsigned SUMX_W = (SUM_W > WSUM_W + 1) ? SUM_W : WSUM_W + 1;
	localparam logic signed [PROD_W-1:0] SPD_MAX = PROD_W'(SPEED_LIMIT);
	localparam logic signed [PROD_W-1:0] SPD_MIN = -SPD_MAX;
	localparam logic signed [SUMX_W-1:0] SUM_MAX = SUMX_W'(SUM_LIMIT);
	localparam logic signed [SUMX_W-1:0] SUM_MIN = -SUM_MAX;

	// configuration
	logic [CFG_W-1:0] zero_offset_q;
	logic [CFG_W-1:0] spike_limit_q;
	logic [CFG_W-1:0] speed_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q <= ZERO_OFFSET_RST;
			spike_limit_q <= SPIKE_LIMIT_RST;
			speed_scale_q <= SPEED_SCALE_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ZERO_OFFSET: zero_offset_q <= cfg_data;
				REG_SPIKE_LIMIT: spike_limit_q <= cfg_data;
				REG_SPEED_SCALE: speed_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	logic             skid_v_q;
	logic [CNT_W-1:0] skid_d_q;
	logic             v_s1, v_s2, v_s3;
	logic             rdy_1, rdy_2, rdy_3, rdy_o;
	logic             tick_acc;
	logic             mv_2;

	assign tick_stall = skid_v_q;
	assign tick_acc   = tick_valid && !skid_v_q;
	assign rdy_o      = !result_valid || !result_stall;
	assign rdy_3      = !v_s3 || rdy_o;
	assign rdy_2      = !v_s2 || rdy_3;
	assign rdy_1      = !v_s1 || rdy_2;
	assign mv_2       = v_s1 && rdy_2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q     <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (rdy_1) skid_v_q <= 1'b0;
			end else if (tick_acc && !rdy_1) begin
				skid_v_q <= 1'b1;
			end
			if (rdy_1) v_s1 <= skid_v_q || tick_acc;
			if (rdy_2) v_s2 <= v_s1;
			if (rdy_3) v_s3 <= v_s2;
			if (rdy_o) result_valid <= v_s3;
		end
	end

	// stage 1: input register
	logic [CNT_W-1:0] cnt_s1;

	always_ff @(posedge clk) begin
		if (!skid_v_q && tick_acc && !rdy_1) skid_d_q <= counter_value;
		if (rdy_1) cnt_s1 <= skid_v_q ? skid_d_q : counter_value;
	end

	// spike rejection and ring update
	pulse_t                    last_pulse_q;
	pulse_t                    pulse_raw;
	pulse_t                    pulse_sel;
	logic signed [PULSE_W:0]   diff;
	logic [PULSE_W:0]          diff_mag;
	logic                      rej;
	logic signed [SUM_W-1:0]   sum_next;

	assign pulse_raw = $signed({1'b0, zero_offset_q}) - $signed({1'b0, cnt_s1});
	assign diff      = (PULSE_W+1)'(last_pulse_q) - (PULSE_W+1)'(pulse_raw);
	assign diff_mag  = diff[PULSE_W] ? unsigned'(-diff) : unsigned'(diff);
	assign rej       = diff_mag > (PULSE_W+1)'(spike_limit_q);
	assign pulse_sel = rej ? last_pulse_q : pulse_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pulse_q <= '0;
		end else if (mv_2) begin
			last_pulse_q <= pulse_sel;
		end
	end

	esf_ring #(
		.AVG_DEPTH(AVG_DEPTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (mv_2),
		.pulse    (pulse_sel),
		.sum_next (sum_next)
	);

	// stage 2: filtered count and window sum
	pulse_t                  pulse_s2;
	logic                    rej_s2;
	logic signed [SUM_W-1:0] sum_s2;

	always_ff @(posedge clk) begin
		if (rdy_2) begin
			pulse_s2 <= pulse_sel;
			rej_s2   <= rej;
			sum_s2   <= sum_next;
		end
	end

	// stage 3: scaled sum
	logic signed [CFG_W:0]    scale_s;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s3;
	pulse_t                   pulse_s3;
	logic                     rej_s3;
	logic signed [SUM_W-1:0]  sum_s3;

	assign scale_s = $signed({1'b0, speed_scale_q});
	assign prod_c  = PROD_W'(sum_s2) * PROD_W'(scale_s);

	always_ff @(posedge clk) begin
		if (rdy_3) begin
			prod_s3  <= prod_c;
			pulse_s3 <= pulse_s2;
			rej_s3   <= rej_s2;
			sum_s3   <= sum_s2;
		end
	end

	// average and saturate
	logic signed [PROD_W-1:0] spd_shift;
	logic signed [PROD_W-1:0] spd_sat;
	logic signed [SUMX_W-1:0] sum_x;
	logic signed [SUMX_W-1:0] sum_sat;
	logic signed [SPEED_W-1:0] last_speed_q;

	assign spd_shift = prod_s3 >>> SHIFT;
	assign sum_x     = SUMX_W'(sum_s3);

	always_comb begin
		priority if (spd_shift > SPD_MAX) begin
			spd_sat = SPD_MAX;
		end else if (spd_shift < SPD_MIN) begin
			spd_sat = SPD_MIN;
		end else begin
			spd_sat = spd_shift;
		end
		priority if (sum_x > SUM_MAX) begin
			sum_sat = SUM_MAX;
		end else if (sum_x < SUM_MIN) begin
			sum_sat = SUM_MIN;
		end else begin
			sum_sat = sum_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_speed_q <= '0;
		end else if (v_s3 && rdy_o) begin
			last_speed_q <= spd_sat[SPEED_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (rdy_o) begin
			accepted_pulse <= pulse_s3;
			spike_rejected <= rej_s3;
			window_sum     <= sum_sat[WSUM_W-1:0];
			avg_speed      <= spd_sat[SPEED_W-1:0];
			previous_speed <= last_speed_q;
		end
	end

endmodule

@@ rtl/esf_checker.sv @@
// Encoder speed filter: port-level checker and its bind to the top level.
// Depends on esf_pkg; watches encoder_speed_filter_core ports only.
module esf_checker import esf_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic signed [PULSE_W-1:0] accepted_pulse,
	input logic                      spike_rejected,
	input logic signed [WSUM_W-1:0]  window_sum,
	input logic signed [SPEED_W-1:0] avg_speed,
	input logic signed [SPEED_W-1:0] previous_speed
);

	localparam logic signed [SPEED_W:0] SPD_MAX = (SPEED_W+1)'(SPEED_LIMIT);
	localparam logic signed [WSUM_W:0]  SUM_MAX = (WSUM_W+1)'(SUM_LIMIT);

	logic                      res_acc;
	logic signed [PULSE_W-1:0] last_pulse_q;
	logic signed [SPEED_W-1:0] last_speed_q;

	assign res_acc = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pulse_q <= '0;
			last_speed_q <= '0;
		end else if (res_acc) begin
			last_pulse_q <= accepted_pulse;
			last_speed_q <= avg_speed;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(accepted_pulse) && $stable(avg_speed))
		else $error("result changed while stalled");

	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && spike_rejected |-> accepted_pulse == last_pulse_q)
		else $error("rejected item does not repeat the previous count");

	a_prev: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc |-> previous_speed == last_speed_q)
		else $error("previous_speed differs from the last delivered speed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			(SPEED_W+1)'(avg_speed) <= SPD_MAX && (SPEED_W+1)'(avg_speed) >= -SPD_MAX &&
			(WSUM_W+1)'(window_sum) <= SUM_MAX && (WSUM_W+1)'(window_sum) >= -SUM_MAX)
		else $error("result outside saturation range");

endmodule

bind encoder_speed_filter_core esf_checker u_esf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.accepted_pulse (accepted_pulse),
	.spike_rejected (spike_rejected),
	.window_sum     (window_sum),
	.avg_speed      (avg_speed),
	.previous_speed (previous_speed)
);
